FILE: rtl/core/scfa_pkg.sv
// Shared types, constants and helpers for the second-chance frame allocator.
package scfa_pkg;

  localparam int FRAMES_DEF       = 1024;
  localparam int FIRST_VICTIM_DEF = 5;

  // Frames are kept in rows of this many frames, one bit per frame per field.
  localparam int ROW_W = 32;
  localparam int BIT_W = 5;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_MAP   = 2'd1,
    FUNC_TOUCH = 2'd2,
    FUNC_FREE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_VICTIM = 2'd1,
    ST_MODE_OFF  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD_RD,
    S_UPD_WR,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SWP_RD,
    S_SWP_EV
  } ctrl_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LATCH,
    DP_READ,
    DP_ECHO,
    DP_UPDATE,
    DP_SCAN,
    DP_SWEEP_START,
    DP_SWEEP,
    DP_MODE_OFF
  } dp_op_t;

  typedef struct packed {
    logic last_row;
    logic in_range;
    logic found;
    logic victim;
    logic cap_done;
    logic sc_enable;
  } dp_sts_t;

  typedef struct packed {
    logic [ROW_W-1:0] referenced;
    logic [ROW_W-1:0] page_kind;
    logic [ROW_W-1:0] mapped;
  } row_t;

  // Position of the lowest set bit; 0 when none is set.
  function automatic logic [BIT_W-1:0] lsb_index(input logic [ROW_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/core/scfa_ctrl.sv
// Sequencer for the frame allocator: clear pass, updates, free search and sweep.
module scfa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           func_code,
  input  scfa_pkg::dp_sts_t    sts,
  output scfa_pkg::dp_op_t     op,
  output logic                 busy,
  output logic                 out_valid
);

  scfa_pkg::ctrl_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scfa_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op            = scfa_pkg::DP_NOP;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      scfa_pkg::S_CLEAR: begin
        op = scfa_pkg::DP_CLEAR;
        if (sts.last_row) begin
          state_nxt = scfa_pkg::S_IDLE;
        end
      end
      scfa_pkg::S_IDLE: begin
        if (start) begin
          op = scfa_pkg::DP_LATCH;
          if (func_code == scfa_pkg::FUNC_ALLOC) begin
            state_nxt = scfa_pkg::S_SCAN_RD;
          end else begin
            state_nxt = scfa_pkg::S_UPD_RD;
          end
        end
      end
      scfa_pkg::S_UPD_RD: begin
        if (sts.in_range) begin
          op        = scfa_pkg::DP_READ;
          state_nxt = scfa_pkg::S_UPD_WR;
        end else begin
          op            = scfa_pkg::DP_ECHO;
          out_valid_nxt = 1'b1;
          state_nxt     = scfa_pkg::S_IDLE;
        end
      end
      scfa_pkg::S_UPD_WR: begin
        op            = scfa_pkg::DP_UPDATE;
        out_valid_nxt = 1'b1;
        state_nxt     = scfa_pkg::S_IDLE;
      end
      scfa_pkg::S_SCAN_RD: begin
        op        = scfa_pkg::DP_READ;
        state_nxt = scfa_pkg::S_SCAN_EV;
      end
      scfa_pkg::S_SCAN_EV: begin
        priority if (sts.found) begin
          op            = scfa_pkg::DP_SCAN;
          out_valid_nxt = 1'b1;
          state_nxt     = scfa_pkg::S_IDLE;
        end else if (!sts.last_row) begin
          op        = scfa_pkg::DP_SCAN;
          state_nxt = scfa_pkg::S_SCAN_RD;
        end else if (sts.sc_enable) begin
          op        = scfa_pkg::DP_SWEEP_START;
          state_nxt = scfa_pkg::S_SWP_RD;
        end else begin
          op            = scfa_pkg::DP_MODE_OFF;
          out_valid_nxt = 1'b1;
          state_nxt     = scfa_pkg::S_IDLE;
        end
      end
      scfa_pkg::S_SWP_RD: begin
        op        = scfa_pkg::DP_READ;
        state_nxt = scfa_pkg::S_SWP_EV;
      end
      scfa_pkg::S_SWP_EV: begin
        op = scfa_pkg::DP_SWEEP;
        if (sts.victim || sts.cap_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = scfa_pkg::S_IDLE;
        end else begin
          state_nxt = scfa_pkg::S_SWP_RD;
        end
      end
      default: begin
        state_nxt = scfa_pkg::S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != scfa_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  a_valid_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start work");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("more than one result for a transaction");

endmodule

FILE: rtl/core/scfa_dp.sv
// Datapath: frame table rows, clock hand, row scanning and result registers.
module scfa_dp #(
  parameter int FRAMES       = scfa_pkg::FRAMES_DEF,
  parameter int FIRST_VICTIM = scfa_pkg::FIRST_VICTIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  scfa_pkg::dp_op_t   op,
  output scfa_pkg::dp_sts_t  sts,
  input  logic [1:0]         in_func,
  input  logic [9:0]         in_frame_index,
  input  logic               in_holds_page,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  output logic [9:0]         out_chosen_frame,
  output logic [1:0]         out_status,
  output logic               out_was_replaced
);

  localparam int ROW_W    = scfa_pkg::ROW_W;
  localparam int BIT_W    = scfa_pkg::BIT_W;
  localparam int ROWS     = (FRAMES + ROW_W - 1) / ROW_W;
  localparam int RAW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FNW      = RAW + BIT_W;
  localparam int LAST_ROW = (FRAMES - 1) / ROW_W;
  localparam int LAST_BIT = (FRAMES - 1) % ROW_W;
  localparam int FV_ROW   = FIRST_VICTIM / ROW_W;
  localparam int FV_BIT   = FIRST_VICTIM % ROW_W;
  // Two laps plus the split start row always reach a victim if one exists.
  localparam int CAP      = 2 * ROWS + 2;
  localparam int VCW      = $clog2(CAP + 1);

  localparam logic [ROW_W-1:0] ONES    = '1;
  localparam logic [ROW_W-1:0] HI_MASK = ONES >> (ROW_W - 1 - LAST_BIT);
  localparam logic [FNW+9:0]   FRAMES_X = (FNW + 10)'(FRAMES);

  scfa_pkg::row_t mem [ROWS];
  scfa_pkg::row_t rd_row_r;
  scfa_pkg::row_t wr_row;
  logic           wr_en;

  logic [RAW-1:0]   cur_row_r;
  logic [BIT_W-1:0] lo_r;
  logic [VCW-1:0]   visits_r;
  logic [RAW-1:0]   hand_row_r;
  logic [BIT_W-1:0] hand_bit_r;
  logic             enable_r;

  scfa_pkg::func_t  func_r;
  logic [9:0]       idx_r;
  logic [BIT_W-1:0] bit_r;
  logic             kind_r;
  logic             in_range_r;

  logic [9:0]              chosen_r;
  scfa_pkg::status_t       status_r;
  logic                    replaced_r;

  logic [FNW+9:0]   idx_x;
  logic [ROW_W-1:0] vmask;
  logic [ROW_W-1:0] free_bits;
  logic [BIT_W-1:0] free_pos;
  logic [ROW_W-1:0] win;
  logic [ROW_W-1:0] cand;
  logic [BIT_W-1:0] vpos;
  logic [ROW_W-1:0] clr_ref;
  logic [FNW+9:0]   free_fx;
  logic [FNW+9:0]   vict_fx;
  logic             last_row;
  logic             hand_at_end;
  logic [RAW-1:0]   sh_row;
  logic [BIT_W-1:0] sh_bit;

  assign idx_x    = {{FNW{1'b0}}, in_frame_index};
  assign last_row = (cur_row_r == RAW'(LAST_ROW));
  assign vmask    = last_row ? HI_MASK : ONES;

  // Free search: lowest unmapped frame in this row
  assign free_bits = ~rd_row_r.mapped & vmask;
  assign free_pos  = scfa_pkg::lsb_index(free_bits);
  assign free_fx   = {10'd0, cur_row_r, free_pos};

  // Sweep: page frames in the window; the first with a clear referenced bit wins
  assign win     = vmask & (ONES << lo_r) & rd_row_r.page_kind;
  assign cand    = win & ~rd_row_r.referenced;
  assign vpos    = scfa_pkg::lsb_index(cand);
  assign vict_fx = {10'd0, cur_row_r, vpos};
  assign clr_ref = (|cand) ? (win & ~(ONES << vpos)) : win;

  // The hand never rests on the last frame at the start of a sweep
  assign hand_at_end = (hand_row_r == RAW'(LAST_ROW)) && (hand_bit_r == BIT_W'(LAST_BIT));
  assign sh_row      = hand_at_end ? RAW'(FV_ROW) : hand_row_r;
  assign sh_bit      = hand_at_end ? BIT_W'(FV_BIT) : hand_bit_r;

  always_comb begin
    wr_row = rd_row_r;
    wr_en  = 1'b0;
    unique case (op)
      scfa_pkg::DP_CLEAR: begin
        wr_row = '0;
        wr_en  = 1'b1;
      end
      scfa_pkg::DP_UPDATE: begin
        wr_en = 1'b1;
        unique case (func_r)
          scfa_pkg::FUNC_MAP: begin
            wr_row.mapped[bit_r]    = 1'b1;
            wr_row.page_kind[bit_r] = kind_r;
          end
          scfa_pkg::FUNC_TOUCH: wr_row.referenced[bit_r] = 1'b1;
          scfa_pkg::FUNC_FREE:  wr_row.mapped[bit_r]     = 1'b0;
          default:              wr_en                    = 1'b0;
        endcase
      end
      scfa_pkg::DP_SWEEP: begin
        wr_en             = 1'b1;
        wr_row.referenced = rd_row_r.referenced & ~clr_ref;
        if (|cand) begin
          wr_row.mapped[vpos] = 1'b0;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur_row_r] <= wr_row;
    end
    if (op == scfa_pkg::DP_READ) begin
      rd_row_r <= mem[cur_row_r];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r  <= '0;
      lo_r       <= '0;
      visits_r   <= '0;
      hand_row_r <= RAW'(FV_ROW);
      hand_bit_r <= BIT_W'(FV_BIT);
      enable_r   <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        enable_r <= cfg_wr_data;
      end
      unique case (op)
        scfa_pkg::DP_CLEAR: cur_row_r <= cur_row_r + RAW'(1);
        scfa_pkg::DP_LATCH: begin
          if (in_func == scfa_pkg::FUNC_ALLOC) begin
            cur_row_r <= '0;
          end else begin
            cur_row_r <= idx_x[BIT_W +: RAW];
          end
        end
        scfa_pkg::DP_SCAN: cur_row_r <= cur_row_r + RAW'(1);
        scfa_pkg::DP_SWEEP_START: begin
          cur_row_r  <= sh_row;
          lo_r       <= sh_bit;
          hand_row_r <= sh_row;
          hand_bit_r <= sh_bit;
          visits_r   <= '0;
        end
        scfa_pkg::DP_SWEEP: begin
          visits_r <= visits_r + VCW'(1);
          if (|cand) begin
            hand_row_r <= cur_row_r;
            hand_bit_r <= vpos;
          end
          if (last_row) begin
            cur_row_r <= RAW'(FV_ROW);
            lo_r      <= BIT_W'(FV_BIT);
          end else begin
            cur_row_r <= cur_row_r + RAW'(1);
            lo_r      <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Transaction and result payload
  always_ff @(posedge clk) begin
    unique case (op)
      scfa_pkg::DP_LATCH: begin
        func_r     <= scfa_pkg::func_t'(in_func);
        idx_r      <= in_frame_index;
        bit_r      <= in_frame_index[BIT_W-1:0];
        kind_r     <= in_holds_page;
        in_range_r <= (idx_x < FRAMES_X);
      end
      scfa_pkg::DP_ECHO, scfa_pkg::DP_UPDATE: begin
        chosen_r   <= idx_r;
        status_r   <= scfa_pkg::ST_OK;
        replaced_r <= 1'b0;
      end
      scfa_pkg::DP_SCAN: begin
        chosen_r   <= free_fx[9:0];
        status_r   <= scfa_pkg::ST_OK;
        replaced_r <= 1'b0;
      end
      scfa_pkg::DP_MODE_OFF: begin
        chosen_r   <= '0;
        status_r   <= scfa_pkg::ST_MODE_OFF;
        replaced_r <= 1'b0;
      end
      scfa_pkg::DP_SWEEP: begin
        if (|cand) begin
          chosen_r   <= vict_fx[9:0];
          status_r   <= scfa_pkg::ST_OK;
          replaced_r <= 1'b1;
        end else begin
          chosen_r   <= '0;
          status_r   <= scfa_pkg::ST_NO_VICTIM;
          replaced_r <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts.last_row  = last_row;
  assign sts.in_range  = in_range_r;
  assign sts.found     = |free_bits;
  assign sts.victim    = |cand;
  assign sts.cap_done  = (visits_r == VCW'(CAP - 1));
  assign sts.sc_enable = enable_r;

  assign out_chosen_frame = chosen_r;
  assign out_status       = status_r;
  assign out_was_replaced = replaced_r;

  a_hand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({hand_row_r, hand_bit_r} >= FNW'(FIRST_VICTIM)) &&
    ({hand_row_r, hand_bit_r} <= FNW'(FRAMES - 1)))
    else $error("clock hand outside the replaceable frames");

  a_victim_moves_hand: assert property (@(posedge clk) disable iff (!rst_n)
    (op == scfa_pkg::DP_SWEEP && (|cand)) |=>
      ({hand_row_r, hand_bit_r} == $past({cur_row_r, vpos})))
    else $error("clock hand not moved to the evicted frame");

endmodule

FILE: rtl/core/second_chance_frame_allocator_core.sv
// Second-chance frame allocator: top level joining sequencer and datapath.
//
// One transaction is taken while busy is low; its result appears one cycle on
// out_valid and cannot be held off. Frame state lives in a table of 32-frame
// rows, read into a register and written back one row at a time. Map, touch and
// free read and rewrite one row. Allocate searches rows from frame 0 and stops at
// the first row with a free frame. With every frame mapped and replacement
// enabled, the clock sweep continues row by row until it evicts a page frame or
// reaches its visit cap. After reset a clearing pass over every row runs with busy
// high; configuration writes are taken throughout.
module second_chance_frame_allocator_core #(
  parameter int FRAMES       = scfa_pkg::FRAMES_DEF,
  parameter int FIRST_VICTIM = scfa_pkg::FIRST_VICTIM_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_func,
  input  logic [9:0] in_frame_index,
  input  logic       in_holds_page,
  output logic       out_valid,
  output logic [9:0] out_chosen_frame,
  output logic [1:0] out_status,
  output logic       out_was_replaced,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  scfa_pkg::dp_op_t  op;
  scfa_pkg::dp_sts_t sts;

  scfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .func_code (in_func),
    .sts       (sts),
    .op        (op),
    .busy      (busy),
    .out_valid (out_valid)
  );

  scfa_dp #(
    .FRAMES       (FRAMES),
    .FIRST_VICTIM (FIRST_VICTIM)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .sts              (sts),
    .in_func          (in_func),
    .in_frame_index   (in_frame_index),
    .in_holds_page    (in_holds_page),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_chosen_frame (out_chosen_frame),
    .out_status       (out_status),
    .out_was_replaced (out_was_replaced)
  );

endmodule

FILE: tb/second_chance_frame_allocator_core_test.sv
// Self-checking testbench for the second-chance frame allocator core.
module second_chance_frame_allocator_core_test;

  localparam int NFR = scfa_pkg::FRAMES_DEF;
  localparam int FV = scfa_pkg::FIRST_VICTIM_DEF;
  localparam int QUIET_LIMIT = 4000;

  typedef struct {
    scfa_pkg::func_t func;
    logic [9:0]      index;
    logic            holds_page;
    logic            follow_alloc;  // index taken from the last allocate result
  } frame_op_t;

  typedef struct {
    logic [9:0]        chosen;
    scfa_pkg::status_t status;
    logic              replaced;
  } frame_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_func = '0;
  logic [9:0] in_frame_index = '0;
  logic       in_holds_page = 1'b0;
  logic       out_valid;
  logic [9:0] out_chosen_frame;
  logic [1:0] out_status;
  logic       out_was_replaced;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b1;

  // Shadow frame table
  logic       frame_mapped [NFR];
  logic       frame_is_page [NFR];
  logic       frame_ref [NFR];
  int         hand;
  logic       repl_mode;
  logic [9:0] last_alloc = '0;

  frame_op_t     queued_ops [$];
  frame_result_t awaited_results [$];
  frame_op_t     cur_op;
  int            page_pick [$];

  int burst_left = 1;
  int gap_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int results_seen = 0;
  int n_evict = 0;
  int n_no_victim = 0;
  int n_mode_off = 0;

  second_chance_frame_allocator_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_frame_index   (in_frame_index),
    .in_holds_page    (in_holds_page),
    .out_valid        (out_valid),
    .out_chosen_frame (out_chosen_frame),
    .out_status       (out_status),
    .out_was_replaced (out_was_replaced),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // Applies one transaction to the shadow table and returns its result.
  function automatic frame_result_t apply_frame_op(frame_op_t op);
    frame_result_t r;
    int f;
    int a;
    int steps;
    logic found;
    logic victim;
    r.chosen = op.index;
    r.status = scfa_pkg::ST_OK;
    r.replaced = 1'b0;
    if (op.func == scfa_pkg::FUNC_ALLOC) begin
      r.chosen = '0;
      found = 1'b0;
      for (f = 0; f < NFR && !found; f++) begin
        if (!frame_mapped[f]) begin
          r.chosen = f[9:0];
          found = 1'b1;
        end
      end
      if (!found && !repl_mode) begin
        r.status = scfa_pkg::ST_MODE_OFF;
      end else if (!found) begin
        if (hand >= NFR || hand + 1 == NFR) hand = FV;
        a = hand;
        victim = 1'b0;
        r.status = scfa_pkg::ST_NO_VICTIM;
        for (steps = 0; steps < 2 * (NFR - FV) && !victim; steps++) begin
          if (frame_is_page[a]) begin
            if (!frame_ref[a]) begin
              frame_mapped[a] = 1'b0;
              hand = a;
              r.chosen = a[9:0];
              r.status = scfa_pkg::ST_OK;
              r.replaced = 1'b1;
              victim = 1'b1;
            end else begin
              frame_ref[a] = 1'b0;
            end
          end
          if (!victim) a = (a + 1 >= NFR) ? FV : a + 1;
        end
      end
    end else if (op.index < NFR) begin
      case (op.func)
        scfa_pkg::FUNC_MAP: begin
          frame_mapped[op.index] = 1'b1;
          frame_is_page[op.index] = op.holds_page;
        end
        scfa_pkg::FUNC_TOUCH: frame_ref[op.index] = 1'b1;
        default: frame_mapped[op.index] = 1'b0;
      endcase
    end
    return r;
  endfunction

  // Driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin : driver
    frame_op_t op;
    frame_result_t res;
    logic go;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      go = start;
      if (start && !busy) begin
        res = apply_frame_op(cur_op);
        awaited_results.push_back(res);
        if (cur_op.func == scfa_pkg::FUNC_ALLOC) last_alloc = res.chosen;
        go = 1'b0;
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (queued_ops.size() != 0) begin
          op = queued_ops.pop_front();
          if (op.follow_alloc) op.index = last_alloc;
          cur_op = op;
          in_func <= op.func;
          in_frame_index <= op.index;
          in_holds_page <= op.holds_page;
          go = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
      start <= go;
    end
  end

  // Monitor: one result per transaction, in order
  always @(posedge clk) begin : monitor
    frame_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: frame %0d status %0d replaced %0d",
                   out_chosen_frame, out_status, out_was_replaced);
      end else begin
        want = awaited_results.pop_front();
        if (out_chosen_frame !== want.chosen || out_status !== want.status ||
            out_was_replaced !== want.replaced) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: frame %0d/%0d status %0d/%0d replaced %0d/%0d",
                     results_seen, want.chosen, out_chosen_frame, want.status,
                     out_status, want.replaced, out_was_replaced);
        end
        if (want.replaced) n_evict++;
        if (want.status == scfa_pkg::ST_NO_VICTIM) n_no_victim++;
        if (want.status == scfa_pkg::ST_MODE_OFF) n_mode_off++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_op(input scfa_pkg::func_t func, input int index, input logic page);
    frame_op_t op;
    op.func = func;
    op.index = index[9:0];
    op.holds_page = page;
    op.follow_alloc = 1'b0;
    queued_ops.push_back(op);
  endtask

  // Map whatever frame the previous allocate handed out
  task automatic push_map_back(input logic page);
    frame_op_t op;
    op.func = scfa_pkg::FUNC_MAP;
    op.index = '0;
    op.holds_page = page;
    op.follow_alloc = 1'b1;
    queued_ops.push_back(op);
  endtask

  task automatic wait_until_drained();
    do @(negedge clk);
    while (queued_ops.size() != 0 || start || awaited_results.size() != 0);
  endtask

  task automatic write_mode(input logic on);
    wait_until_drained();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= on;
    repl_mode = on;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic steady_traffic(input int n);
    int r;
    int f;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        push_op(scfa_pkg::FUNC_ALLOC, $urandom_range(0, NFR - 1), 1'($urandom_range(0, 1)));
      end else if (r < 60) begin
        push_map_back($urandom_range(0, 4) != 0);
      end else if (r < 80) begin
        if ($urandom_range(0, 9) < 7)
          f = page_pick[$urandom_range(0, page_pick.size() - 1)];
        else
          f = $urandom_range(0, NFR - 1);
        push_op(scfa_pkg::FUNC_TOUCH, f, 1'($urandom_range(0, 1)));
      end else if (r < 90) begin
        f = $urandom_range(FV, NFR - 1);
        page_pick.push_back(f);
        push_op(scfa_pkg::FUNC_MAP, f, 1'b1);
      end else if (r < 96) begin
        push_op(scfa_pkg::FUNC_FREE, $urandom_range(0, NFR - 1), 1'($urandom_range(0, 1)));
      end else begin
        push_op(scfa_pkg::FUNC_MAP, $urandom_range(0, NFR - 1), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int f;
    for (f = 0; f < NFR; f++) begin
      frame_mapped[f] = 1'b0;
      frame_is_page[f] = 1'b0;
      frame_ref[f] = 1'b0;
    end
    hand = FV;
    repl_mode = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(1'b1);

    // Directed: lowest free frame, map kinds, touch, double free, edge indices
    push_op(scfa_pkg::FUNC_ALLOC, 0, 0);
    push_op(scfa_pkg::FUNC_MAP, 0, 1);
    push_op(scfa_pkg::FUNC_ALLOC, 1023, 1);
    push_op(scfa_pkg::FUNC_MAP, 1, 0);
    push_op(scfa_pkg::FUNC_TOUCH, 0, 0);
    push_op(scfa_pkg::FUNC_TOUCH, 1023, 1);
    push_op(scfa_pkg::FUNC_FREE, 1, 0);
    push_op(scfa_pkg::FUNC_ALLOC, 0, 0);
    push_op(scfa_pkg::FUNC_FREE, 1, 1);
    push_op(scfa_pkg::FUNC_MAP, 1023, 1);
    push_op(scfa_pkg::FUNC_MAP, 682, 0);
    push_op(scfa_pkg::FUNC_MAP, 341, 1);
    push_op(scfa_pkg::FUNC_FREE, 1023, 0);
    push_op(scfa_pkg::FUNC_MAP, 1023, 0);
    push_op(scfa_pkg::FUNC_TOUCH, FV, 0);
    push_op(scfa_pkg::FUNC_MAP, 2, 1);
    push_op(scfa_pkg::FUNC_MAP, 3, 0);
    push_op(scfa_pkg::FUNC_MAP, 4, 1);
    push_op(scfa_pkg::FUNC_ALLOC, 0, 0);
    push_op(scfa_pkg::FUNC_FREE, 0, 0);
    push_op(scfa_pkg::FUNC_ALLOC, 0, 0);
    push_map_back(1'b1);
    push_op(scfa_pkg::FUNC_ALLOC, 0, 0);

    // Mixed traffic while free frames remain, biased towards low frames
    repeat (40) begin
      f = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, NFR - 1);
      if ($urandom_range(0, 4) == 0)
        push_map_back(1'($urandom_range(0, 1)));
      else
        push_op(scfa_pkg::func_t'($urandom_range(0, 3)), f, 1'($urandom_range(0, 1)));
    end

    // Fill the table with no page frames in the victim range: sweeps must fail
    for (f = 0; f < NFR; f++)
      push_op(scfa_pkg::FUNC_MAP, f, (f < FV) ? 1'($urandom_range(0, 1)) : 1'b0);
    push_op(scfa_pkg::FUNC_ALLOC, 0, 0);
    push_op(scfa_pkg::FUNC_TOUCH, 600, 0);
    push_op(scfa_pkg::FUNC_ALLOC, 0, 0);
    push_op(scfa_pkg::FUNC_ALLOC, 0, 0);

    write_mode(1'b0);
    push_op(scfa_pkg::FUNC_ALLOC, 0, 0);
    push_op(scfa_pkg::FUNC_MAP, 7, 0);
    push_op(scfa_pkg::FUNC_ALLOC, 0, 0);
    write_mode(1'b1);

    // Seed page frames, including both ends of the victim range
    page_pick.push_back(FV);
    page_pick.push_back(NFR - 1);
    repeat (38) page_pick.push_back($urandom_range(FV, NFR - 1));
    foreach (page_pick[i]) push_op(scfa_pkg::FUNC_MAP, page_pick[i], 1'b1);
    repeat (20)
      push_op(scfa_pkg::FUNC_TOUCH, page_pick[$urandom_range(0, page_pick.size() - 1)], 0);

    steady_traffic(40);
    write_mode(1'b0);
    steady_traffic(10);
    write_mode(1'b1);
    steady_traffic(40);

    wait_until_drained();
    repeat (20) @(posedge clk);
    $display("%0d transactions checked: %0d evictions, %0d sweeps without victim,",
             results_seen, n_evict, n_no_victim);
    $display("%0d allocations refused with replacement off, %0d mismatches",
             n_mode_off, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/scfa_pkg.sv
rtl/core/scfa_ctrl.sv
rtl/core/scfa_dp.sv
rtl/core/second_chance_frame_allocator_core.sv
tb/second_chance_frame_allocator_core_test.sv
